// ===== src/sc2d_pkg.sv =====
// shared constants, codes, structs and helpers of the strided 2-d convolution block
// no dependencies; imported by every other file of the block
package sc2d_pkg;

    // sizes of the stores and of the stored data
    localparam int MAX_DIM    = 64;
    localparam int MAX_KERNEL = 8;
    localparam int DATA_WIDTH = 16;

    // fixed field widths of the ports
    localparam int OP_W       = 2;
    localparam int ROW_W      = 7;
    localparam int VAL_W      = 16;
    localparam int SUM_W      = 38;
    localparam int ST_W       = 2;
    localparam int DIMF_W     = 7;
    localparam int KDIMF_W    = 4;
    localparam int STEP_W     = 4;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // derived internal widths
    localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int KIDX_W    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int IR_W      = $clog2(MAX_DIM + 1);
    localparam int KR_W      = $clog2(MAX_KERNEL + 1);
    localparam int SPAN_W    = $clog2(MAX_DIM + 2 * MAX_KERNEL);
    localparam int NUM_W     = $clog2(MAX_DIM + 2 * MAX_KERNEL + (1 << STEP_W));
    localparam int OUT_W     = NUM_W + 1;
    localparam int DIV_CNT_W = $clog2(NUM_W + 2);
    localparam int POS_W     = ROW_W + STEP_W + 1;
    localparam int IMG_AW    = 2 * IDX_W;
    localparam int KER_AW    = 2 * KIDX_W;
    localparam int IMG_DEPTH = 1 << IMG_AW;
    localparam int KER_DEPTH = 1 << KER_AW;
    localparam int PROD_W    = 2 * DATA_WIDTH;
    localparam int EXT_W     = (PROD_W > SUM_W) ? PROD_W : SUM_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_WR_IMAGE  = OP_W'(0);
    localparam logic [OP_W-1:0] OP_WR_KERNEL = OP_W'(1);
    localparam logic [OP_W-1:0] OP_COMPUTE   = OP_W'(2);

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = ST_W'(0);
    localparam logic [ST_W-1:0] ST_MODE  = ST_W'(1);
    localparam logic [ST_W-1:0] ST_KSIZE = ST_W'(2);
    localparam logic [ST_W-1:0] ST_RANGE = ST_W'(3);

    // padding modes
    localparam logic [MODE_W-1:0] MODE_VALID = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_FULL  = MODE_W'(1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_MODE    = CFG_IDX_W'(5);

    // geometry derived from the configuration registers
    typedef struct packed {
        logic [IR_W-1:0]   ir;
        logic [IR_W-1:0]   ic;
        logic [KR_W-1:0]   kr;
        logic [KR_W-1:0]   kc;
        logic [STEP_W-1:0] step;
        logic [KR_W-1:0]   off_r;
        logic [KR_W-1:0]   off_c;
        logic [SPAN_W-1:0] dr;
        logic [SPAN_W-1:0] dc;
        logic [ST_W-1:0]   err;
        logic [OUT_W-1:0]  orows;
        logic [OUT_W-1:0]  ocols;
        logic              ready;
    } t_cfg_info;

    // read request from the window walker to the stores
    typedef struct packed {
        logic              en;
        logic [IMG_AW-1:0] img_addr;
        logic [KER_AW-1:0] ker_addr;
    } t_rd_req;

    // write request from the item decode to the stores
    typedef struct packed {
        logic                  img_we;
        logic                  ker_we;
        logic [IMG_AW-1:0]     img_addr;
        logic [KER_AW-1:0]     ker_addr;
        logic [DATA_WIDTH-1:0] data;
    } t_wr_req;

    // sign-extend the written value and wrap it to the stored width
    function automatic logic [DATA_WIDTH-1:0] to_store(input logic signed [VAL_W-1:0] v);
        logic signed [31:0] ext;
        ext = 32'(v);
        return ext[DATA_WIDTH-1:0];
    endfunction

endpackage

// ===== src/sc2d_cfg.sv =====
// configuration registers, derived geometry and serial output-size divider
// depends on sc2d_pkg
module sc2d_cfg import sc2d_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg_info             o_info
);

    localparam logic [DIV_CNT_W-1:0] DIV_LOAD = DIV_CNT_W'(NUM_W + 1);

    logic [DIMF_W-1:0]  r_image_rows, r_image_cols;
    logic [KDIMF_W-1:0] r_kernel_rows, r_kernel_cols;
    logic [STEP_W-1:0]  r_step_size;
    logic [MODE_W-1:0]  r_pad_mode;

    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [STEP_W-1:0]    r_rem_r, r_rem_c;
    logic [NUM_W-1:0]     r_quo_r, r_quo_c;

    logic [IR_W-1:0]   ir, ic;
    logic [KR_W-1:0]   kr, kc, off_r, off_c;
    logic [STEP_W-1:0] step;
    logic [SPAN_W-1:0] dr, dc;
    logic [ST_W-1:0]   err;
    logic [NUM_W-1:0]  num_r, num_c;
    logic [STEP_W:0]   rsh_r, rsh_c, diff_r, diff_c;
    logic              ge_r, ge_c;
    logic              cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    // saturate dimensions to their legal ranges
    assign ir = (r_image_rows == '0) ? IR_W'(1) :
                (int'(r_image_rows) > MAX_DIM) ? IR_W'(MAX_DIM) : IR_W'(r_image_rows);
    assign ic = (r_image_cols == '0) ? IR_W'(1) :
                (int'(r_image_cols) > MAX_DIM) ? IR_W'(MAX_DIM) : IR_W'(r_image_cols);
    assign kr = (r_kernel_rows == '0) ? KR_W'(1) :
                (int'(r_kernel_rows) > MAX_KERNEL) ? KR_W'(MAX_KERNEL) : KR_W'(r_kernel_rows);
    assign kc = (r_kernel_cols == '0) ? KR_W'(1) :
                (int'(r_kernel_cols) > MAX_KERNEL) ? KR_W'(MAX_KERNEL) : KR_W'(r_kernel_cols);
    assign step = (r_step_size == '0) ? STEP_W'(1) : r_step_size;

    always_comb begin
        off_r = '0;
        off_c = '0;
        dr    = SPAN_W'(ir);
        dc    = SPAN_W'(ic);
        err   = ST_OK;
        if (r_pad_mode == MODE_FULL && !(kr == KR_W'(1) && kc == KR_W'(1))) begin
            off_r = kr - KR_W'(1);
            off_c = kc - KR_W'(1);
            dr    = SPAN_W'(ir) + (SPAN_W'(off_r) << 1);
            dc    = SPAN_W'(ic) + (SPAN_W'(off_c) << 1);
        end else if (r_pad_mode == MODE_VALID) begin
            if (SPAN_W'(ir) < SPAN_W'(kr) || SPAN_W'(ic) < SPAN_W'(kc)) begin
                err = ST_KSIZE;
            end
        end else begin
            err = ST_MODE;
        end
    end

    // rounded-up span: (d - k + s - 1) / s, plus one below
    assign num_r = NUM_W'(dr) - NUM_W'(kr) + NUM_W'(step) - NUM_W'(1);
    assign num_c = NUM_W'(dc) - NUM_W'(kc) + NUM_W'(step) - NUM_W'(1);

    // one quotient bit per cycle, rows and columns side by side
    assign rsh_r  = {r_rem_r, r_quo_r[NUM_W-1]};
    assign rsh_c  = {r_rem_c, r_quo_c[NUM_W-1]};
    assign diff_r = rsh_r - {1'b0, step};
    assign diff_c = rsh_c - {1'b0, step};
    assign ge_r   = rsh_r >= {1'b0, step};
    assign ge_c   = rsh_c >= {1'b0, step};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_rows  <= DIMF_W'(64);
            r_image_cols  <= DIMF_W'(64);
            r_kernel_rows <= KDIMF_W'(3);
            r_kernel_cols <= KDIMF_W'(3);
            r_step_size   <= STEP_W'(1);
            r_pad_mode    <= MODE_VALID;
            r_div_cnt     <= DIV_LOAD;
        end else begin
            if (cfg_wr) begin
                case (i_cfg_index)
                    CFG_IMAGE_ROWS:  r_image_rows  <= i_cfg_data[DIMF_W-1:0];
                    CFG_IMAGE_COLS:  r_image_cols  <= i_cfg_data[DIMF_W-1:0];
                    CFG_KERNEL_ROWS: r_kernel_rows <= i_cfg_data[KDIMF_W-1:0];
                    CFG_KERNEL_COLS: r_kernel_cols <= i_cfg_data[KDIMF_W-1:0];
                    CFG_STEP_SIZE:   r_step_size   <= i_cfg_data[STEP_W-1:0];
                    CFG_PAD_MODE:    r_pad_mode    <= i_cfg_data[MODE_W-1:0];
                    default: ;
                endcase
                r_div_cnt <= DIV_LOAD;
            end else if (r_div_cnt != '0) begin
                r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_div_cnt == DIV_LOAD) begin
            r_quo_r <= num_r;
            r_quo_c <= num_c;
            r_rem_r <= '0;
            r_rem_c <= '0;
        end else if (r_div_cnt != '0) begin
            r_quo_r <= {r_quo_r[NUM_W-2:0], ge_r};
            r_quo_c <= {r_quo_c[NUM_W-2:0], ge_c};
            r_rem_r <= ge_r ? diff_r[STEP_W-1:0] : rsh_r[STEP_W-1:0];
            r_rem_c <= ge_c ? diff_c[STEP_W-1:0] : rsh_c[STEP_W-1:0];
        end
    end

    always_comb begin
        o_info       = '0;
        o_info.ir    = ir;
        o_info.ic    = ic;
        o_info.kr    = kr;
        o_info.kc    = kc;
        o_info.step  = step;
        o_info.off_r = off_r;
        o_info.off_c = off_c;
        o_info.dr    = dr;
        o_info.dc    = dc;
        o_info.err   = err;
        o_info.orows = (err == ST_OK) ? OUT_W'(r_quo_r) + OUT_W'(1) : '0;
        o_info.ocols = (err == ST_OK) ? OUT_W'(r_quo_c) + OUT_W'(1) : '0;
        o_info.ready = (r_div_cnt == '0);
    end

endmodule

// ===== src/sc2d_store.sv =====
// image and kernel stores, one write and one registered read per cycle each
// depends on sc2d_pkg
module sc2d_store import sc2d_pkg::*; (
    input  logic                         i_clk,
    input  t_wr_req                      i_wr,
    input  t_rd_req                      i_rd,
    output logic signed [DATA_WIDTH-1:0] o_img_q,
    output logic signed [DATA_WIDTH-1:0] o_ker_q
);

    logic [DATA_WIDTH-1:0] r_image_mem  [IMG_DEPTH];
    logic [DATA_WIDTH-1:0] r_kernel_mem [KER_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.img_we) begin
            r_image_mem[i_wr.img_addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            o_img_q <= r_image_mem[i_rd.img_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.ker_we) begin
            r_kernel_mem[i_wr.ker_addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            o_ker_q <= r_kernel_mem[i_rd.ker_addr];
        end
    end

endmodule

// ===== src/sc2d_mac.sv =====
// window walker and multiply-accumulate pipeline over the stores
// depends on sc2d_pkg; drives the read port of sc2d_store
module sc2d_mac import sc2d_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cfg_info                    i_cfg,
    input  logic                         i_start,
    input  logic [ROW_W-1:0]             i_row,
    input  logic [ROW_W-1:0]             i_col,
    output t_rd_req                      o_rd,
    input  logic signed [DATA_WIDTH-1:0] i_img_q,
    input  logic signed [DATA_WIDTH-1:0] i_ker_q,
    output logic                         o_done,
    output logic [SUM_W-1:0]             o_sum
);

    logic               r_run;
    logic [POS_W-1:0]   r_base_r, r_base_c;
    logic [KIDX_W-1:0]  r_ki, r_kj;
    logic               r_v1, r_ok1, r_last1;
    logic               r_v2, r_last2;
    logic signed [PROD_W-1:0] r_prod;
    logic [SUM_W-1:0]   r_acc;
    logic               r_done;

    logic [POS_W-1:0]   row, col, row_rel, col_rel;
    logic               row_ok, col_ok, last_col, last;
    logic signed [PROD_W-1:0] prod;
    logic signed [EXT_W-1:0]  prod_ext;

    assign row     = r_base_r + POS_W'(r_ki);
    assign col     = r_base_c + POS_W'(r_kj);
    assign row_rel = row - POS_W'(i_cfg.off_r);
    assign col_rel = col - POS_W'(i_cfg.off_c);

    // cells beyond the data or in the zero border contribute nothing
    assign row_ok = row < POS_W'(i_cfg.dr) && row >= POS_W'(i_cfg.off_r)
                    && row_rel < POS_W'(i_cfg.ir);
    assign col_ok = col < POS_W'(i_cfg.dc) && col >= POS_W'(i_cfg.off_c)
                    && col_rel < POS_W'(i_cfg.ic);

    assign last_col = KR_W'(r_kj) == i_cfg.kc - KR_W'(1);
    assign last     = last_col && (KR_W'(r_ki) == i_cfg.kr - KR_W'(1));

    always_comb begin
        o_rd          = '0;
        o_rd.en       = r_run;
        o_rd.img_addr = {IDX_W'(row_rel), IDX_W'(col_rel)};
        o_rd.ker_addr = {r_ki, r_kj};
    end

    assign prod     = i_img_q * i_ker_q;
    assign prod_ext = EXT_W'(r_prod);

    // walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_v1   <= r_run;
            r_v2   <= r_v1;
            r_done <= r_v2 && r_last2;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && last) begin
                r_run <= 1'b0;
            end
        end
    end

    // window position, product and sum
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_base_r <= POS_W'(i_row * i_cfg.step);
            r_base_c <= POS_W'(i_col * i_cfg.step);
            r_ki     <= '0;
            r_kj     <= '0;
        end else if (r_run && !last) begin
            if (last_col) begin
                r_kj <= '0;
                r_ki <= r_ki + KIDX_W'(1);
            end else begin
                r_kj <= r_kj + KIDX_W'(1);
            end
        end
        r_ok1   <= row_ok && col_ok;
        r_last1 <= r_run && last;
        r_last2 <= r_v1 && r_last1;
        r_prod  <= r_ok1 ? prod : '0;
        if (i_start) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + prod_ext[SUM_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_acc;

endmodule

// ===== src/strided_2d_convolution.sv =====
// top level of the strided 2-d cross-correlation engine
// depends on sc2d_pkg, sc2d_cfg, sc2d_store and sc2d_mac
//
// channel   direction  handshake                 payload
// -------   ---------  ------------------------  -------------------------------------------
// in        sink       i_in_valid / o_in_stall   i_operation, i_row_index, i_col_index,
//                                                i_element_value
// out       source     o_out_valid / i_out_stall o_conv_sum, o_status, o_out_rows, o_out_cols
// cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one item at a time: a write item passes through the done state to the output register;
// a compute item without error first runs the window walk in the busy state through the single multiply-
// accumulate (one image and one kernel word read per cycle)
// after reset and after every configuration write the input stalls while the serial
// divider settles the output size
// the stores are not cleared; entries hold their value until written
// a finished result waits in its own register until the output register is free, so
// the next item is taken while the output side is stalled
module strided_2d_convolution import sc2d_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input item channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [ROW_W-1:0]        i_row_index,
    input  logic [ROW_W-1:0]        i_col_index,
    input  logic signed [VAL_W-1:0] i_element_value,
    // result channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [SUM_W-1:0] o_conv_sum,
    output logic [ST_W-1:0]         o_status,
    output logic [ROW_W-1:0]        o_out_rows,
    output logic [ROW_W-1:0]        o_out_cols,
    // configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    // idle: ready for a transfer; busy: window walk running; done: result parked
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BUSY = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state;

    t_cfg_info cfg_info;
    t_rd_req   rd_req;
    t_wr_req   wr_req;

    logic signed [DATA_WIDTH-1:0] img_q, ker_q;
    logic                         mac_start, mac_done;
    logic [SUM_W-1:0]             mac_sum;

    // parked result of the item in hand
    logic [SUM_W-1:0] r_res_sum;
    logic [ST_W-1:0]  r_res_status;
    logic [ROW_W-1:0] r_res_rows, r_res_cols;

    // output register
    logic             r_out_valid;
    logic [SUM_W-1:0] r_out_sum;
    logic [ST_W-1:0]  r_out_status;
    logic [ROW_W-1:0] r_out_rows, r_out_cols;

    logic            in_fire, out_free;
    logic            img_in, ker_in, pos_in;
    logic [ST_W-1:0] acc_status;

    sc2d_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_info      (cfg_info)
    );

    sc2d_store u_store (
        .i_clk   (i_clk),
        .i_wr    (wr_req),
        .i_rd    (rd_req),
        .o_img_q (img_q),
        .o_ker_q (ker_q)
    );

    sc2d_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_info),
        .i_start (mac_start),
        .i_row   (i_row_index),
        .i_col   (i_col_index),
        .o_rd    (rd_req),
        .i_img_q (img_q),
        .i_ker_q (ker_q),
        .o_done  (mac_done),
        .o_sum   (mac_sum)
    );

    // a transfer is taken only when idle and the output size is settled
    assign o_in_stall = !(r_state == S_IDLE && cfg_info.ready);
    assign in_fire    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // address range checks of the item
    assign img_in = int'(i_row_index) < MAX_DIM && int'(i_col_index) < MAX_DIM;
    assign ker_in = int'(i_row_index) < MAX_KERNEL && int'(i_col_index) < MAX_KERNEL;
    assign pos_in = int'(i_row_index) < int'(cfg_info.orows)
                    && int'(i_col_index) < int'(cfg_info.ocols);

    always_comb begin
        case (i_operation)
            OP_WR_IMAGE:  acc_status = img_in ? ST_OK : ST_RANGE;
            OP_WR_KERNEL: acc_status = ker_in ? ST_OK : ST_RANGE;
            OP_COMPUTE: begin
                if (cfg_info.err != ST_OK) begin
                    acc_status = cfg_info.err;
                end else begin
                    acc_status = pos_in ? ST_OK : ST_RANGE;
                end
            end
            default:      acc_status = ST_RANGE;
        endcase
    end

    // writes land in the store at the transfer edge; the walk of a later compute
    // starts only after that, so reads never see a stale entry
    always_comb begin
        wr_req          = '0;
        wr_req.img_we   = in_fire && i_operation == OP_WR_IMAGE && img_in;
        wr_req.ker_we   = in_fire && i_operation == OP_WR_KERNEL && ker_in;
        wr_req.img_addr = {IDX_W'(i_row_index), IDX_W'(i_col_index)};
        wr_req.ker_addr = {KIDX_W'(i_row_index), KIDX_W'(i_col_index)};
        wr_req.data     = to_store(i_element_value);
    end

    assign mac_start = in_fire && i_operation == OP_COMPUTE && acc_status == ST_OK;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= mac_start ? S_BUSY : S_DONE;
                    end
                end
                S_BUSY: begin
                    if (mac_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload; the size fields follow the configuration at transfer time
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res_sum    <= '0;
            r_res_status <= acc_status;
            r_res_rows   <= ROW_W'(cfg_info.orows);
            r_res_cols   <= ROW_W'(cfg_info.ocols);
        end else if (r_state == S_BUSY && mac_done) begin
            r_res_sum <= mac_sum;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_sum    <= r_res_sum;
            r_out_status <= r_res_status;
            r_out_rows   <= r_res_rows;
            r_out_cols   <= r_res_cols;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_conv_sum  = r_out_sum;
    assign o_status    = r_out_status;
    assign o_out_rows  = r_out_rows;
    assign o_out_cols  = r_out_cols;

    // the walk only finishes while an item is in hand
    a_done_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_done |-> r_state == S_BUSY)
        else $error("walk finished outside busy state");

    // no item is taken before the output size is settled
    a_fire_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> cfg_info.ready)
        else $error("item taken while divider running");

    // a started walk moves the control to busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_start |=> r_state == S_BUSY)
        else $error("walk started without busy state");

    // an error result carries a zero sum
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> o_conv_sum == '0)
        else $error("non-zero sum on error result");

    // store writes never overlap a window walk
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_req.img_we || wr_req.ker_we) |-> !rd_req.en)
        else $error("store write during window walk");

endmodule
